// File: sv/fcfgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcfgc_pkg
// Shared types, constants and CRC functions of the frame footer generator
// and checker.
// ----------------------------------------------------------------------------
package fcfgc_pkg;

	// Largest frame, payload plus footer, in bytes.
	localparam int unsigned MAX_FRAME_BYTES = 8;

	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
	localparam logic [3:0]  COUNT_MAX = 4'd15;

	localparam logic [3:0] GEN_MAX_LEN   = 4'(MAX_FRAME_BYTES - 1);
	localparam logic [4:0] CHECK_MAX_LEN = 5'(MAX_FRAME_BYTES);

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_LEN_ERR   = 2'd1,
		STATUS_CHECK_ERR = 2'd2
	} status_t;

	// Command codes.
	localparam logic CMD_GENERATE = 1'b0;
	localparam logic CMD_CHECK    = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] footer_byte;
		logic [1:0] status;
		logic [3:0] payload_length;
	} result_t;

	// Next state and optional result of one frame byte.
	typedef struct packed {
		logic [31:0] crc;
		logic [3:0]  count;
		logic        has_result;
		result_t     result;
	} calc_t;

	// One reflected CRC-32 byte step, one bit per iteration.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Footer: CRC-32 of the low byte of the finished payload CRC, low 8 bits.
	function automatic logic [7:0] footer_of(input logic [31:0] crc_reg);
		logic [31:0] first;
		logic [31:0] second;
		first  = crc_reg ^ CRC_ONES;
		second = crc_byte(CRC_ONES, first[7:0]) ^ CRC_ONES;
		return second[7:0];
	endfunction

endpackage
`default_nettype wire

// File: sv/fcfgc_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcfgc_calc
// Combinational step of one frame byte: CRC and count update, and the
// footer result on the byte marked last.
// ----------------------------------------------------------------------------
module fcfgc_calc
	import fcfgc_pkg::*;
(
	input  wire logic [31:0] crc,
	input  wire logic [3:0]  count,
	input  wire item_t       item,
	output calc_t            calc
);

	logic [31:0] crc_add;
	logic [3:0]  count_add;
	logic [4:0]  frame_len;

	// Byte taken as payload.
	assign crc_add   = crc_byte(crc, item.data_byte);
	assign count_add = (count < COUNT_MAX) ? count + 4'd1 : count;
	assign frame_len = {1'b0, count} + 5'd1;

	// Result and next state selection.
	always_comb begin
		calc = '0;
		if (!item.last) begin
			calc.crc        = crc_add;
			calc.count      = count_add;
			calc.has_result = 1'b0;
		end else begin
			// The last byte ends the frame and returns the state to reset.
			calc.crc        = CRC_ONES;
			calc.count      = 4'd0;
			calc.has_result = 1'b1;
			if (item.cmd == CMD_GENERATE) begin
				calc.result.payload_length = count_add;
				if (count_add < 4'd1 || count_add > GEN_MAX_LEN) begin
					calc.result.status = STATUS_LEN_ERR;
				end else begin
					calc.result.status      = STATUS_OK;
					calc.result.footer_byte = footer_of(crc_add);
				end
			end else begin
				calc.result.payload_length = count;
				if (frame_len < 5'd2 || frame_len > CHECK_MAX_LEN) begin
					calc.result.status = STATUS_CHECK_ERR;
				end else begin
					calc.result.footer_byte = footer_of(crc);
					calc.result.status = (footer_of(crc) != item.data_byte) ?
						STATUS_CHECK_ERR : STATUS_OK;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/frame_crc_footer_gen_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_crc_footer_gen_check
// Frame footer generator and checker with a truncated CRC-32 footer.
//
// Frame bytes arrive on the item channel, one per transaction, with a mode
// (generate or check) and a last mark. Bytes before the last one update a
// reflected CRC-32 and a saturating byte count and give no result. The byte
// marked last gives one transaction on the result channel: in generate mode
// it is the final payload byte and the footer is emitted; in check mode it is
// the received footer, compared with the computed one.
// Both channels use valid and stall. An item is registered in the first
// stage, worked combinationally, and its result is registered in the output
// register, from which it is presented on the result channel. One item is
// taken per cycle while the item channel does not stall.
// When the receiver stalls, the result holds and a pending last byte waits in
// the first stage, which stalls the item channel; bytes not marked last keep
// flowing. Reset clears both stages and returns the CRC to all ones and the
// count to zero.
// ----------------------------------------------------------------------------
module frame_crc_footer_gen_check
	import fcfgc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     result_s2;
	logic [31:0] crc_q;
	logic [3:0]  count_q;
	calc_t       calc;
	logic        s2_free;
	logic        advance_s1;

	// Byte step on the registered item.
	fcfgc_calc u_calc (
		.crc   (crc_q),
		.count (count_q),
		.item  (item_s1),
		.calc  (calc)
	);

	// A byte without a result always moves on; a last byte needs a free slot.
	assign s2_free    = !valid_s2 || !result_stall;
	assign advance_s1 = valid_s1 && (!item_s1.last || s2_free);
	assign item_stall = valid_s1 && !advance_s1;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Running CRC and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_ONES;
			count_q <= 4'd0;
		end else if (advance_s1) begin
			crc_q   <= calc.crc;
			count_q <= calc.count;
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance_s1 && calc.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && advance_s1 && calc.has_result) begin
			result_s2 <= calc.result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
`default_nettype wire
